/* hdl/assert_macros.svh */
// Assertion macros shared by the queue modules.
// Needs signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock outside reset.
`define CTMQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ctmq assertion failed");

// Condition in one cycle implies the property in the next one.
`define CTMQ_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("ctmq assertion failed");

`endif

/* hdl/ctmq_pkg.sv */
// Shared types and constants of the channel-tagged message queue.
// No dependencies; used by ctmq_store, ctmq_seq and the top level.
package ctmq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Opcodes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_PUSH   = 3'd1;
  localparam logic [2:0] OP_TAKE   = 3'd2;
  localparam logic [2:0] OP_PEEK   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        match_channel;
    logic [7:0]  channel;
    logic [31:0] payload_ref;
    logic [15:0] length;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  channel_out;
    logic [15:0] length_out;
    logic [31:0] payload_out;
  } out_rsp_t;

  // One stored descriptor
  typedef struct packed {
    logic [7:0]  channel;
    logic [15:0] length;
    logic [31:0] payload_ref;
  } entry_t;

  // Sequencer to store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              use_match;
    logic [7:0]        match_chan;
  } mem_cmd_t;

  // Store to sequencer
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    entry_t            entry;
  } mem_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DOWN,
    S_UP
  } state_t;

endpackage

/* hdl/channel_tagged_message_queue.sv */
// Top level of the channel-tagged message queue.
// Depends on ctmq_pkg, ctmq_store and ctmq_seq.

// Ordered queue of up to DEPTH descriptors (channel, length, payload
// reference) in one single-port-write, single-port-read memory, worked by
// a small sequencer. A request is taken when start is high and busy is low;
// exactly one result follows as a one-cycle out_valid strobe, and the
// receiver cannot stall it. Busy drops in the strobe cycle, so the next
// request may be taken then. Append, clear, unused opcodes, a full queue
// for append or push, or an empty one for take or peek answer straight
// from the dispatch state; push front moves every entry up one slot at
// one entry per cycle and then writes slot 0; a take or peek reads the
// entries in order, one memory read per cycle through the channel
// comparator, and answers on a hit or after the last entry; a take with
// entries behind the removed one first closes the gap and then answers.
module channel_tagged_message_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ctmq_pkg::in_req_t   in_req,
  output logic                out_valid,
  output ctmq_pkg::out_rsp_t  out_rsp
);

  ctmq_pkg::mem_cmd_t mem_cmd;
  ctmq_pkg::mem_rsp_t mem_rsp;

  // Sequencer
  ctmq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .mem_cmd   (mem_cmd),
    .mem_rsp   (mem_rsp)
  );

  // Descriptor store
  ctmq_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .rsp   (mem_rsp)
  );

endmodule

/* hdl/ctmq_store.sv */
// Descriptor memory with registered read port and the channel comparator.
// Depends on ctmq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctmq_store (
  input  logic                clk,
  input  logic                rst_n,
  input  ctmq_pkg::mem_cmd_t  cmd,
  output ctmq_pkg::mem_rsp_t  rsp
);

  ctmq_pkg::entry_t                    mem_r [ctmq_pkg::DEPTH];
  ctmq_pkg::entry_t                    rd_entry_r;
  logic [ctmq_pkg::ADDR_W-1:0]         rd_addr_r;
  logic                                rd_vld_r;

  // Write port and registered read data
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem_r[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rd_entry_r <= mem_r[cmd.raddr];
      rd_addr_r  <= cmd.raddr;
    end
  end

  // Read data valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.re;
    end
  end

  // Shared compare unit: any entry hits when no channel match is asked for
  always_comb begin
    rsp.valid = rd_vld_r;
    rsp.addr  = rd_addr_r;
    rsp.entry = rd_entry_r;
    rsp.hit   = rd_vld_r && (!cmd.use_match || (rd_entry_r.channel == cmd.match_chan));
  end

  // Shifts never read and write the same slot in one cycle
  `CTMQ_ASSERT(a_no_rw_clash, (cmd.we && cmd.re) |-> (cmd.waddr != cmd.raddr))

endmodule

/* hdl/ctmq_seq.sv */
// Sequencer: request decode, scan and shift loops, entry count and result.
// Depends on ctmq_pkg and assert_macros.svh; drives ctmq_store.
`include "assert_macros.svh"

module ctmq_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ctmq_pkg::in_req_t   in_req,
  output logic                out_valid,
  output ctmq_pkg::out_rsp_t  out_rsp,
  output ctmq_pkg::mem_cmd_t  mem_cmd,
  input  ctmq_pkg::mem_rsp_t  mem_rsp
);

  ctmq_pkg::state_t            state_r, state_nxt;
  ctmq_pkg::in_req_t           req_r, req_nxt;
  logic [ctmq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ctmq_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  ctmq_pkg::entry_t            got_r, got_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ctmq_pkg::out_rsp_t          out_rsp_r, out_rsp_nxt;

  logic                        accept;
  logic                        full;
  logic                        scan_more;
  logic                        up_more;
  logic                        is_take;
  logic                        tail_left;
  logic [ctmq_pkg::CNT_W-1:0]  next_pos;
  logic                        fin;
  logic [1:0]                  fin_status;
  ctmq_pkg::entry_t            fin_entry;
  ctmq_pkg::entry_t            new_entry;

  // Address one below a nonzero count
  function automatic logic [ctmq_pkg::ADDR_W-1:0] idx_nxt_addr(
    input logic [ctmq_pkg::CNT_W-1:0] idx
  );
    logic [ctmq_pkg::CNT_W-1:0] dec;
    dec = idx - ctmq_pkg::CNT_W'(1);
    return dec[ctmq_pkg::ADDR_W-1:0];
  endfunction

  // Shared conditions
  assign busy      = (state_r != ctmq_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_r == ctmq_pkg::CNT_W'(ctmq_pkg::DEPTH));
  assign scan_more = (idx_r < count_r);
  assign up_more   = (idx_r != '0);
  assign is_take   = (req_r.opcode == ctmq_pkg::OP_TAKE);
  assign next_pos  = ctmq_pkg::CNT_W'(mem_rsp.addr) + ctmq_pkg::CNT_W'(1);
  assign tail_left = (next_pos < count_r);
  assign new_entry = '{channel: req_r.channel, length: req_r.length,
                       payload_ref: req_r.payload_ref};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctmq_pkg::S_IDLE: begin
        if (accept) state_nxt = ctmq_pkg::S_DISPATCH;
      end
      ctmq_pkg::S_DISPATCH: begin
        state_nxt = ctmq_pkg::S_IDLE;
        if ((req_r.opcode == ctmq_pkg::OP_PUSH) && !full) begin
          state_nxt = ctmq_pkg::S_UP;
        end else if (((req_r.opcode == ctmq_pkg::OP_TAKE) ||
                      (req_r.opcode == ctmq_pkg::OP_PEEK)) && (count_r != '0)) begin
          state_nxt = ctmq_pkg::S_SCAN;
        end
      end
      ctmq_pkg::S_SCAN: begin
        if (mem_rsp.hit) begin
          state_nxt = (is_take && tail_left) ? ctmq_pkg::S_DOWN : ctmq_pkg::S_IDLE;
        end else if (!scan_more && !mem_rsp.valid) begin
          state_nxt = ctmq_pkg::S_IDLE;
        end
      end
      ctmq_pkg::S_DOWN: begin
        if (!scan_more && !mem_rsp.valid) state_nxt = ctmq_pkg::S_IDLE;
      end
      ctmq_pkg::S_UP: begin
        if (!up_more && !mem_rsp.valid) state_nxt = ctmq_pkg::S_IDLE;
      end
      default: state_nxt = ctmq_pkg::S_IDLE;
    endcase
  end

  // Datapath control per state
  always_comb begin
    req_nxt            = req_r;
    count_nxt          = count_r;
    idx_nxt            = idx_r;
    got_nxt            = got_r;
    fin                = 1'b0;
    fin_status         = ctmq_pkg::STAT_OK;
    fin_entry          = '0;
    mem_cmd            = '0;
    mem_cmd.use_match  = req_r.match_channel;
    mem_cmd.match_chan = req_r.channel;
    unique case (state_r)
      ctmq_pkg::S_IDLE: begin
        if (accept) req_nxt = in_req;
      end
      ctmq_pkg::S_DISPATCH: begin
        unique case (req_r.opcode) inside
          ctmq_pkg::OP_APPEND: begin
            fin = 1'b1;
            if (full) begin
              fin_status = ctmq_pkg::STAT_FULL;
            end else begin
              mem_cmd.we    = 1'b1;
              mem_cmd.waddr = count_r[ctmq_pkg::ADDR_W-1:0];
              mem_cmd.wdata = new_entry;
              count_nxt     = count_r + ctmq_pkg::CNT_W'(1);
            end
          end
          ctmq_pkg::OP_PUSH: begin
            if (full) begin
              fin        = 1'b1;
              fin_status = ctmq_pkg::STAT_FULL;
            end else begin
              idx_nxt = count_r;
            end
          end
          ctmq_pkg::OP_TAKE, ctmq_pkg::OP_PEEK: begin
            idx_nxt = '0;
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ctmq_pkg::STAT_NOT_FOUND;
            end
          end
          ctmq_pkg::OP_CLEAR: begin
            fin       = 1'b1;
            count_nxt = '0;
          end
          default: fin = 1'b1;
        endcase
      end
      // One read per cycle, compared in the cycle after the read
      ctmq_pkg::S_SCAN: begin
        if (mem_rsp.hit) begin
          got_nxt = mem_rsp.entry;
          if (is_take && tail_left) begin
            idx_nxt = next_pos;
          end else begin
            fin       = 1'b1;
            fin_entry = mem_rsp.entry;
            if (is_take) count_nxt = count_r - ctmq_pkg::CNT_W'(1);
          end
        end else if (scan_more) begin
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = idx_r[ctmq_pkg::ADDR_W-1:0];
          idx_nxt       = idx_r + ctmq_pkg::CNT_W'(1);
        end else if (!mem_rsp.valid) begin
          fin        = 1'b1;
          fin_status = ctmq_pkg::STAT_NOT_FOUND;
        end
      end
      // Close the gap: entry i+1 moves to i
      ctmq_pkg::S_DOWN: begin
        if (mem_rsp.valid) begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = mem_rsp.addr - ctmq_pkg::ADDR_W'(1);
          mem_cmd.wdata = mem_rsp.entry;
        end
        if (scan_more) begin
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = idx_r[ctmq_pkg::ADDR_W-1:0];
          idx_nxt       = idx_r + ctmq_pkg::CNT_W'(1);
        end else if (!mem_rsp.valid) begin
          fin       = 1'b1;
          fin_entry = got_r;
          count_nxt = count_r - ctmq_pkg::CNT_W'(1);
        end
      end
      // Open slot 0: entry i moves to i+1, newest index first
      ctmq_pkg::S_UP: begin
        if (mem_rsp.valid) begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = mem_rsp.addr + ctmq_pkg::ADDR_W'(1);
          mem_cmd.wdata = mem_rsp.entry;
        end
        if (up_more) begin
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = idx_nxt_addr(idx_r);
          idx_nxt       = idx_r - ctmq_pkg::CNT_W'(1);
        end else if (!mem_rsp.valid) begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = '0;
          mem_cmd.wdata = new_entry;
          count_nxt     = count_r + ctmq_pkg::CNT_W'(1);
          fin           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt           = fin;
    out_rsp_nxt.status      = fin_status;
    out_rsp_nxt.channel_out = fin_entry.channel;
    out_rsp_nxt.length_out  = fin_entry.length;
    out_rsp_nxt.payload_out = fin_entry.payload_ref;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctmq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    got_r     <= got_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `CTMQ_ASSERT(a_count_range, count_r <= ctmq_pkg::CNT_W'(ctmq_pkg::DEPTH))
  `CTMQ_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r)
  `CTMQ_ASSERT(a_full_drop, (out_valid_r && (out_rsp_r.status == ctmq_pkg::STAT_FULL)) |-> full)
  `CTMQ_ASSERT(a_miss_zero, (out_valid_r && (out_rsp_r.status == ctmq_pkg::STAT_NOT_FOUND)) |-> ((out_rsp_r.channel_out == '0) && (out_rsp_r.length_out == '0) && (out_rsp_r.payload_out == '0)))
  `CTMQ_ASSERT(a_idle_no_read, (state_r == ctmq_pkg::S_IDLE) |-> !mem_rsp.valid)

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for channel_tagged_message_queue: directed and random requests,
// each result checked field by field against a shadow queue kept in a small class.
// Depends on ctmq_pkg and the queue RTL; reads no files.
module testbench;

  // Opcodes the block must ignore
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int RANDOM_REQS   = 700;
  localparam int DRAIN_EVERY   = 150;
  localparam int SETTLE_CYCLES = 2 * ctmq_pkg::DEPTH + 8;

  // Shadow of the descriptor queue plus the results still owed by the block
  class queue_checker;
    ctmq_pkg::entry_t   shadow[$];
    ctmq_pkg::out_rsp_t expected_rsp[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one request to the shadow queue and return the result it owes
    function ctmq_pkg::out_rsp_t predict_result(input ctmq_pkg::in_req_t r);
      ctmq_pkg::out_rsp_t rsp;
      ctmq_pkg::entry_t   e;
      int                 pos;
      rsp = '0;
      rsp.status = ctmq_pkg::STAT_OK;
      e.channel = r.channel;
      e.length = r.length;
      e.payload_ref = r.payload_ref;
      case (r.opcode)
        ctmq_pkg::OP_APPEND, ctmq_pkg::OP_PUSH: begin
          if (shadow.size() >= ctmq_pkg::DEPTH) rsp.status = ctmq_pkg::STAT_FULL;
          else if (r.opcode == ctmq_pkg::OP_APPEND) shadow.push_back(e);
          else shadow.push_front(e);
        end
        ctmq_pkg::OP_TAKE, ctmq_pkg::OP_PEEK: begin
          // oldest entry, or oldest with a matching channel
          pos = 0;
          if (r.match_channel) begin
            pos = shadow.size();
            for (int i = shadow.size() - 1; i >= 0; i--)
              if (shadow[i].channel == r.channel) pos = i;
          end
          if (pos >= shadow.size()) begin
            rsp.status = ctmq_pkg::STAT_NOT_FOUND;
          end else begin
            rsp.channel_out = shadow[pos].channel;
            rsp.length_out = shadow[pos].length;
            rsp.payload_out = shadow[pos].payload_ref;
            if (r.opcode == ctmq_pkg::OP_TAKE) shadow.delete(pos);
          end
        end
        ctmq_pkg::OP_CLEAR: shadow.delete();
        default: ;
      endcase
      return rsp;
    endfunction

    function void note_request(input ctmq_pkg::in_req_t r);
      expected_rsp.push_back(predict_result(r));
    endfunction

    task check_result(input ctmq_pkg::out_rsp_t got);
      ctmq_pkg::out_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("result with no request pending: %h", got));
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.channel_out !== want.channel_out)
        report($sformatf("channel_out %h, expected %h", got.channel_out, want.channel_out));
      if (got.length_out !== want.length_out)
        report($sformatf("length_out %h, expected %h", got.length_out, want.length_out));
      if (got.payload_out !== want.payload_out)
        report($sformatf("payload_out %h, expected %h", got.payload_out, want.payload_out));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  ctmq_pkg::in_req_t  in_req;
  logic               out_valid;
  ctmq_pkg::out_rsp_t out_rsp;

  queue_checker qchk = new();

  channel_tagged_message_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("status: fail");
    $finish;
  end

  // Sample both channels on the clock edge; result first, then a new request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) qchk.check_result(out_rsp);
      if (start && !busy) qchk.note_request(in_req);
    end
  end

  function automatic ctmq_pkg::in_req_t make_req(input logic [2:0] op, input logic m,
                                                 input logic [7:0] ch,
                                                 input logic [31:0] pref,
                                                 input logic [15:0] len);
    ctmq_pkg::in_req_t r;
    r.opcode = op;
    r.match_channel = m;
    r.channel = ch;
    r.payload_ref = pref;
    r.length = len;
    return r;
  endfunction

  // mode 0 fills the queue, mode 1 drains it, anything else mixes
  function automatic ctmq_pkg::in_req_t random_req(input int mode);
    ctmq_pkg::in_req_t r;
    int                w;
    int                cut[5];
    r.match_channel = ($urandom_range(0, 99) < 60);
    // a few channels most of the time so that matches hit
    r.channel = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    r.payload_ref = $urandom;
    case ($urandom_range(0, 3))
      0: r.length = '0;
      1: r.length = '1;
      default: r.length = 16'($urandom);
    endcase
    case (mode)
      0: cut = '{45, 70, 85, 95, 97};
      1: cut = '{15, 25, 70, 92, 94};
      default: cut = '{30, 45, 72, 90, 93};
    endcase
    w = $urandom_range(0, 99);
    if (w < cut[0]) r.opcode = ctmq_pkg::OP_APPEND;
    else if (w < cut[1]) r.opcode = ctmq_pkg::OP_PUSH;
    else if (w < cut[2]) r.opcode = ctmq_pkg::OP_TAKE;
    else if (w < cut[3]) r.opcode = ctmq_pkg::OP_PEEK;
    else if (w < cut[4]) r.opcode = ctmq_pkg::OP_CLEAR;
    else r.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    return r;
  endfunction

  // Mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Hold start high until the block takes the request
  task automatic send_req(input ctmq_pkg::in_req_t r);
    in_req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (qchk.expected_rsp.size() != 0);
  endtask

  initial begin
    ctmq_pkg::in_req_t directed[$];
    int                mode;
    int                mode_left;
    int                burst_left;
    start <= 1'b0;
    in_req <= '0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue, field extremes, middle removal, misses, ignored opcodes, full queue
    directed.push_back(make_req(ctmq_pkg::OP_TAKE, 1'b0, 8'h00, 32'h0, 16'h0));
    directed.push_back(make_req(ctmq_pkg::OP_PEEK, 1'b1, 8'hff, 32'h0, 16'h0));
    directed.push_back(make_req(ctmq_pkg::OP_APPEND, 1'b0, 8'h00, 32'h0, 16'h0));
    directed.push_back(make_req(ctmq_pkg::OP_APPEND, 1'b1, 8'hff, 32'hffff_ffff,
                                16'hffff));
    directed.push_back(make_req(ctmq_pkg::OP_PUSH, 1'b0, 8'h07, 32'h1234_5678, 16'h00ff));
    directed.push_back(make_req(ctmq_pkg::OP_PEEK, 1'b0, 8'h55, 32'h0, 16'h0));
    directed.push_back(make_req(ctmq_pkg::OP_TAKE, 1'b1, 8'hff, 32'h0, 16'h0));
    directed.push_back(make_req(ctmq_pkg::OP_TAKE, 1'b1, 8'h63, 32'h0, 16'h0));
    for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++)
      directed.push_back(make_req(3'(o), 1'b1, 8'hff, 32'hffff_ffff, 16'hffff));
    for (int i = 0; i < ctmq_pkg::DEPTH - 2; i++)
      directed.push_back(make_req(ctmq_pkg::OP_APPEND, 1'b0, 8'(16 + i), $urandom, 16'(i)));
    directed.push_back(make_req(ctmq_pkg::OP_APPEND, 1'b0, 8'haa, 32'hdead_beef, 16'h1111));
    directed.push_back(make_req(ctmq_pkg::OP_PUSH, 1'b0, 8'hbb, 32'hcafe_f00d, 16'h2222));
    directed.push_back(make_req(ctmq_pkg::OP_TAKE, 1'b1, 8'(16 + ctmq_pkg::DEPTH / 2),
                                32'h0, 16'h0));
    directed.push_back(make_req(ctmq_pkg::OP_CLEAR, 1'b0, 8'h00, 32'h0, 16'h0));
    foreach (directed[i]) begin
      send_req(directed[i]);
      hold_off(pick_gap());
    end
    wait_drained();

    // Random traffic in fill, drain and mixed phases
    mode = 2;
    mode_left = 0;
    burst_left = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      send_req(random_req(mode));
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        wait_drained();
      end else begin
        if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          hold_off(pick_gap());
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (qchk.expected_rsp.size() != 0) qchk.report("results still owed at end of run");
    if (qchk.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
